// File: rtl/track_superlayer_break_filter_unit_defines.svh
// Assertion macros shared by the filter RTL.
`ifndef TRACK_SUPERLAYER_BREAK_FILTER_UNIT_DEFINES_SVH
`define TRACK_SUPERLAYER_BREAK_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define TSBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsbf: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off during reset.
`define TSBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsbf: next-cycle check failed");

`endif

// File: rtl/tsbf_pkg.sv
package tsbf_pkg;

    localparam int MAX_HITS  = 64;
    localparam int NUM_SL    = 9;

    localparam int ARC_W     = 24;
    localparam int APO_W     = 23;
    localparam int LAYER_W   = 4;
    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int LCNT_W    = 7;
    localparam int STEP_W    = LAYER_W + 1;

    localparam logic [LCNT_W-1:0]  LCNT_MAX = {LCNT_W{1'b1}};
    localparam logic [LAYER_W-1:0] BRK_NONE = LAYER_W'(NUM_SL);

    typedef logic signed [ARC_W-1:0] arc_t;
    typedef logic [LAYER_W-1:0]      layer_t;
    typedef logic [IDX_W-1:0]        idx_t;

endpackage

// File: rtl/tsbf_hit_store.sv
module tsbf_hit_store
(
    input  logic            clk,
    input  logic            we,
    input  tsbf_pkg::idx_t   waddr,
    input  tsbf_pkg::arc_t   warc,
    input  tsbf_pkg::layer_t wlayer,
    input  tsbf_pkg::idx_t   raddr,
    output tsbf_pkg::arc_t   rarc,
    output tsbf_pkg::layer_t rlayer
);
    import tsbf_pkg::*;

    arc_t   arc_mem   [MAX_HITS];
    layer_t layer_mem [MAX_HITS];
    arc_t   rarc_reg;
    layer_t rlayer_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            arc_mem[waddr]   <= warc;
            layer_mem[waddr] <= wlayer;
        end
        rarc_reg   <= arc_mem[raddr];
        rlayer_reg <= layer_mem[raddr];
    end

    assign rarc   = rarc_reg;
    assign rlayer = rlayer_reg;

endmodule

// File: rtl/track_superlayer_break_filter_unit.sv
// Superlayer break filter for the hits of one track. Hits are taken one per cycle
// while collecting (s_tready high) and stored, up to MAX_HITS; extra hits are dropped
// and flagged. After the hit marked by s_tlast the block is busy: a layer scan walks
// all NUM_SL layer counters, a hole search steps by two from the first used layer, and
// then each stored hit yields one result, set by the registered read of the hit store
// followed by the shared keep compare; a result held back by m_tready stalls the next
// read. The next track may start while the last result still waits on the output.
`include "track_superlayer_break_filter_unit_defines.svh"

module track_superlayer_break_filter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // arc_length[23:0], super_layer[27:24], zero[31:28]
    input  logic        s_tlast,   // last_hit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // hit_index[5:0], keep[6], clear_taken[7],
                                   // break_layer[11:8], overflowed[12], zero[15:13]
    output logic        m_tlast,   // last_result
    input  logic        cfg_we,
    input  logic [tsbf_pkg::APO_W-1:0] cfg_wdata
);
    import tsbf_pkg::*;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_STEP    = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [APO_W-1:0]   apogee_reg;
    logic [LCNT_W-1:0]  lcnt_reg [NUM_SL];
    logic [CNT_W-1:0]   hit_count_reg;
    logic               ovf_reg;
    logic [STEP_W-1:0]  i_reg, i_next;
    layer_t             first_reg, first_next;
    layer_t             last_reg, last_next;
    logic               found_reg, found_next;
    layer_t             brk_reg, brk_next;
    idx_t               k_reg, k_next;

    logic               m_tvalid_reg;
    idx_t               out_idx_reg;
    logic               out_keep_reg;
    logic               out_clear_reg;
    layer_t             out_brk_reg;
    logic               out_ovf_reg;
    logic               out_last_reg;

    arc_t               in_arc;
    layer_t             in_layer;
    logic               in_accept;
    logic               in_store;
    logic               in_fwd;
    logic [LCNT_W-1:0]  cnt_sel;
    arc_t               rd_arc;
    layer_t             rd_layer;
    logic               out_load;
    logic               k_last;
    logic               has_break;
    logic               keep_calc;
    logic               track_done;

    assign in_arc    = s_tdata[ARC_W-1:0];
    assign in_layer  = s_tdata[ARC_W +: LAYER_W];
    assign s_tready  = (state_reg == S_COLLECT);
    assign in_accept = s_tvalid && s_tready;
    assign in_store  = in_accept && (hit_count_reg < CNT_W'(MAX_HITS));
    assign in_fwd    = !in_arc[ARC_W-1] && (in_arc[APO_W-1:0] != '0)
                       && (in_arc[APO_W-1:0] <= apogee_reg)
                       && (in_layer < LAYER_W'(NUM_SL));

    tsbf_hit_store u_store
    (
        .clk    (clk),
        .we     (in_store),
        .waddr  (hit_count_reg[IDX_W-1:0]),
        .warc   (in_arc),
        .wlayer (in_layer),
        .raddr  (k_reg),
        .rarc   (rd_arc),
        .rlayer (rd_layer)
    );

    always_comb
    begin
        cnt_sel = '0;
        for (int j = 0; j < NUM_SL; j++)
        begin
            if (i_reg == STEP_W'(j))
            begin
                cnt_sel = lcnt_reg[j];
            end
        end
    end

    assign has_break  = (brk_reg != BRK_NONE);
    assign keep_calc  = !has_break
                        || (!rd_arc[ARC_W-1] && (rd_arc[APO_W-1:0] < apogee_reg)
                            && (rd_layer < brk_reg));
    assign k_last     = (({1'b0, k_reg} + CNT_W'(1)) == hit_count_reg);
    assign out_load   = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign track_done = out_load && k_last;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        first_next = first_reg;
        last_next  = last_reg;
        found_next = found_reg;
        brk_next   = brk_reg;
        k_next     = k_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_accept && s_tlast)
                begin
                    state_next = S_SCAN;
                    i_next     = '0;
                    found_next = 1'b0;
                    first_next = '0;
                    last_next  = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_sel != '0)
                begin
                    if (!found_reg)
                    begin
                        first_next = i_reg[LAYER_W-1:0];
                    end
                    last_next  = i_reg[LAYER_W-1:0];
                    found_next = 1'b1;
                end
                if (i_reg == STEP_W'(NUM_SL - 1))
                begin
                    state_next = S_STEP;
                    i_next     = {1'b0, first_next};
                end
                else
                begin
                    i_next = i_reg + STEP_W'(1);
                end
            end
            S_STEP:
            begin
                if (!found_reg || (i_reg > {1'b0, last_reg}))
                begin
                    brk_next   = BRK_NONE;
                    k_next     = '0;
                    state_next = S_READ;
                end
                else if (cnt_sel == '0)
                begin
                    brk_next   = i_reg[LAYER_W-1:0];
                    k_next     = '0;
                    state_next = S_READ;
                end
                else
                begin
                    i_next = i_reg + STEP_W'(2);
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    if (k_last)
                    begin
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            apogee_reg    <= '0;
            hit_count_reg <= '0;
            ovf_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            i_reg         <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            found_reg     <= 1'b0;
            brk_reg       <= BRK_NONE;
            k_reg         <= '0;
            for (int j = 0; j < NUM_SL; j++)
            begin
                lcnt_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            first_reg <= first_next;
            last_reg  <= last_next;
            found_reg <= found_next;
            brk_reg   <= brk_next;
            k_reg     <= k_next;

            if (cfg_we)
            begin
                apogee_reg <= cfg_wdata;
            end

            if (track_done)
            begin
                hit_count_reg <= '0;
                ovf_reg       <= 1'b0;
            end
            else if (in_store)
            begin
                hit_count_reg <= hit_count_reg + CNT_W'(1);
            end
            else if (in_accept)
            begin
                ovf_reg <= 1'b1;
            end

            for (int j = 0; j < NUM_SL; j++)
            begin
                if (track_done)
                begin
                    lcnt_reg[j] <= '0;
                end
                else if (in_store && in_fwd && (in_layer == LAYER_W'(j))
                         && (lcnt_reg[j] != LCNT_MAX))
                begin
                    lcnt_reg[j] <= lcnt_reg[j] + LCNT_W'(1);
                end
            end

            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg   <= k_reg;
            out_keep_reg  <= keep_calc;
            out_clear_reg <= has_break;
            out_brk_reg   <= brk_reg;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= k_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_ovf_reg, out_brk_reg, out_clear_reg, out_keep_reg,
                       out_idx_reg};

    `TSBF_ASSERT_NOW(a_emit_index_in_range, state_reg == S_EMIT,
                     ({1'b0, k_reg} < hit_count_reg))
    `TSBF_ASSERT_NEXT(a_track_clears, track_done,
                      (hit_count_reg == '0) && !ovf_reg && (state_reg == S_COLLECT))
    `TSBF_ASSERT_NEXT(a_full_sets_overflow,
                      in_accept && !in_store && !track_done, ovf_reg)

endmodule
